### src/srm_pkg.sv
`timescale 1ns / 1ps
package srm_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int POS_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int COUNT_W      = 5;
  localparam int CNT_CMP_W    = (POS_W > COUNT_W) ? POS_W : COUNT_W;
  localparam int IDX_W        = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_TEXT = 2'd1,
    KIND_END  = 2'd2
  } srm_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEMENT_COUNT = 2'd0,
    CFG_ANCHOR_START  = 2'd1,
    CFG_ANCHOR_END    = 2'd2
  } srm_cfg_idx_t;

  // shared per-cycle control broadcast to all cells
  typedef struct packed {
    logic       rearm;
    logic       step;
    logic [7:0] text_char;
    logic [7:0] elem_char;
    logic       elem_any;
    logic       elem_star;
  } srm_ctrl_t;

  // neighbor link: closure carry and advance into the next position
  typedef struct packed {
    logic closed;
    logic advance;
  } srm_link_t;

endpackage

### src/srm_in_if.sv
`timescale 1ns / 1ps
interface srm_in_if;
  import srm_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [IDX_W-1:0] element_index;
  logic [7:0]       element_char;
  logic             element_any;
  logic             element_star;
  logic [7:0]       text_char;

  modport source (
    output valid, kind, element_index, element_char, element_any, element_star, text_char,
    input  ready
  );
  modport sink (
    input  valid, kind, element_index, element_char, element_any, element_star, text_char,
    output ready
  );
endinterface

### src/srm_out_if.sv
`timescale 1ns / 1ps
interface srm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink (input valid, matched, output ready);
endinterface

### src/srm_cfg_if.sv
`timescale 1ns / 1ps
interface srm_cfg_if;
  import srm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/simple_regex_matcher.sv
`timescale 1ns / 1ps
// Streaming matcher for simple patterns of literal or any-byte elements, each
// optionally starred, with start/end anchors in config registers. Load beats
// (kind 0) write one element, text beats (kind 1) advance the active position
// set, and an end beat (kind 2) returns one result beat carrying the verdict
// and re-arms for the next text; loads and config writes re-arm as well. A
// beat is accepted each cycle while the result register is empty or being
// drained. The position set lives in a row of MAX_ELEMENTS cells plus a tail
// bit; the star closure ripples through the cells within the cycle, so the row
// length sets the critical path. Config writes are taken at any time but must
// only be issued while idle.
module simple_regex_matcher (
  input logic       clk,
  input logic       rst_n,
  srm_in_if.sink    in_bus,
  srm_out_if.source out_bus,
  srm_cfg_if.sink   cfg_bus
);
  import srm_pkg::*;

  logic [COUNT_W-1:0]    count_r;
  logic                  anchor_start_r;
  logic                  anchor_end_r;
  logic                  sticky_r;
  logic                  sticky_nxt;
  logic                  tail_r;
  logic                  tail_nxt;
  logic                  out_valid_r;
  logic                  out_matched_r;
  logic                  in_fire;
  logic                  cfg_fire;
  logic                  cfg_hit;
  logic                  is_load;
  logic                  is_text;
  logic                  is_end;
  logic                  rearm;
  logic [POS_W-1:0]      used_n;
  logic [MAX_ELEMENTS:0] act_vec;
  logic                  at_end;
  logic                  found;
  srm_ctrl_t             ctrl;
  srm_link_t             link [MAX_ELEMENTS+1];

  assign in_bus.ready  = ~out_valid_r | out_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign in_fire       = in_bus.valid & in_bus.ready;
  assign cfg_fire      = cfg_bus.valid & cfg_bus.ready;

  always_comb begin
    is_load = 1'b0;
    is_text = 1'b0;
    is_end  = 1'b0;
    case (in_bus.kind)
      KIND_LOAD: is_load = in_fire;
      KIND_TEXT: is_text = in_fire;
      KIND_END:  is_end  = in_fire;
      default: ;
    endcase
  end

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_bus.index)
      CFG_ELEMENT_COUNT: cfg_hit = cfg_fire;
      CFG_ANCHOR_START:  cfg_hit = cfg_fire;
      CFG_ANCHOR_END:    cfg_hit = cfg_fire;
      default: ;
    endcase
  end

  assign rearm = cfg_hit | is_load | is_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r        <= '0;
      anchor_start_r <= 1'b0;
      anchor_end_r   <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_bus.index)
        CFG_ELEMENT_COUNT: count_r        <= cfg_bus.data[COUNT_W-1:0];
        CFG_ANCHOR_START:  anchor_start_r <= cfg_bus.data[0];
        CFG_ANCHOR_END:    anchor_end_r   <= cfg_bus.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (CNT_CMP_W'(count_r) > CNT_CMP_W'(MAX_ELEMENTS)) begin
      used_n = POS_W'(MAX_ELEMENTS);
    end else begin
      used_n = POS_W'(count_r);
    end
  end

  assign ctrl.rearm     = rearm;
  assign ctrl.step      = is_text;
  assign ctrl.text_char = in_bus.text_char;
  assign ctrl.elem_char = in_bus.element_char;
  assign ctrl.elem_any  = in_bus.element_any;
  assign ctrl.elem_star = in_bus.element_star;

  assign link[0].closed  = 1'b0;
  assign link[0].advance = ~anchor_start_r;

  for (genvar p = 0; p < MAX_ELEMENTS; p++) begin : g_cell
    logic sel;
    logic en;
    assign sel = is_load && (int'(in_bus.element_index) == p);
    assign en  = POS_W'(p) < used_n;

    srm_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .sel    (sel),
      .en     (en),
      .home   (p == 0),
      .link_i (link[p]),
      .link_o (link[p+1]),
      .act_o  (act_vec[p])
    );
  end

  assign act_vec[MAX_ELEMENTS] = tail_r | link[MAX_ELEMENTS].closed;
  assign at_end = act_vec[used_n];
  assign found  = sticky_r | (~anchor_end_r & at_end);

  always_comb begin
    tail_nxt   = tail_r;
    sticky_nxt = sticky_r;
    if (rearm) begin
      tail_nxt   = 1'b0;
      sticky_nxt = 1'b0;
    end else if (is_text) begin
      tail_nxt   = link[MAX_ELEMENTS].advance;
      sticky_nxt = found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r      <= 1'b0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tail_r   <= tail_nxt;
      sticky_r <= sticky_nxt;
      if (is_end) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_end) begin
      out_matched_r <= sticky_r | at_end;
    end
  end

  assign out_bus.valid   = out_valid_r;
  assign out_bus.matched = out_matched_r;

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_end |=> out_valid_r)
    else $error("end beat did not produce a result");

  a_rearm_clears_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    rearm |=> !sticky_r && !tail_r)
    else $error("re-arm left stale match state");

  a_rearm_seeds_start: assert property (@(posedge clk) disable iff (!rst_n)
    rearm |=> act_vec[0])
    else $error("position zero not active after re-arm");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bus.ready |-> !in_fire)
    else $error("input accepted while result stalled");

endmodule

### src/srm_cell.sv
`timescale 1ns / 1ps
module srm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  srm_pkg::srm_ctrl_t ctrl,
  input  logic              sel,
  input  logic              en,
  input  logic              home,
  input  srm_pkg::srm_link_t link_i,
  output srm_pkg::srm_link_t link_o,
  output logic              act_o
);
  import srm_pkg::*;

  logic [7:0] elem_char_r;
  logic       elem_any_r;
  logic       elem_star_r;
  logic       seed_r;
  logic       seed_nxt;
  logic       act;
  logic       hit;

  assign act = seed_r | link_i.closed;
  assign hit = elem_any_r | (elem_char_r == ctrl.text_char);

  assign link_o.closed  = act & en & elem_star_r;
  assign link_o.advance = act & en & hit & ~elem_star_r;
  assign act_o          = act;

  always_comb begin
    seed_nxt = seed_r;
    if (ctrl.rearm) begin
      seed_nxt = home;
    end else if (ctrl.step) begin
      seed_nxt = (act & en & hit & elem_star_r) | link_i.advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= home;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      elem_char_r <= ctrl.elem_char;
      elem_any_r  <= ctrl.elem_any;
      elem_star_r <= ctrl.elem_star;
    end
  end

endmodule
